// ----- sv/srtf_pkg.sv -----
package srtf_pkg;

  localparam int TIME_W  = 21;
  localparam int PID_W   = 8;
  localparam int ARR_W   = 16;
  localparam int BURST_W = 16;
  localparam int MODE_W  = 2;

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic               best_found;
    logic [BURST_W-1:0] best_rem;
    logic [PID_W-1:0]   best_pid;
    logic [ARR_W-1:0]   best_arr;
    logic [BURST_W-1:0] best_burst;
    logic               run_found;
    logic [BURST_W-1:0] run_rem;
    logic [PID_W-1:0]   run_pid;
    logic [ARR_W-1:0]   run_arr;
    logic [BURST_W-1:0] run_burst;
  } cand_t;

  typedef struct packed {
    logic               wr_en;
    logic               dec_en;
    logic               run_valid;
    logic [PID_W-1:0]   pid;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  cur_time;
  } bcast_t;

endpackage

// ----- sv/srtf_cell.sv -----
module srtf_cell
  import srtf_pkg::*;
#(
  parameter int MAX_PROCS = 16,
  parameter int IDX = 0,
  localparam int SLOT_W = $clog2(MAX_PROCS),
  localparam int CNT_W = $clog2(MAX_PROCS + 1)
) (
  input  logic              clk,
  input  bcast_t            bcast,
  input  logic [SLOT_W-1:0] wr_slot,
  input  logic [SLOT_W-1:0] dec_slot,
  input  logic [SLOT_W-1:0] run_slot,
  input  logic [CNT_W-1:0]  entry_count,
  input  cand_t             cand_i,
  input  logic [SLOT_W-1:0] best_idx_i,
  output cand_t             cand_o,
  output logic [SLOT_W-1:0] best_idx_o
);

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);
  localparam logic [CNT_W-1:0]  MY_CNT  = CNT_W'(IDX);

  logic [PID_W-1:0]   pid_r;
  logic [ARR_W-1:0]   arr_r;
  logic [BURST_W-1:0] burst_r;
  logic [BURST_W-1:0] rem_r;

  cand_t             cand_r;
  cand_t             cand_nxt;
  logic [SLOT_W-1:0] idx_r;
  logic [SLOT_W-1:0] idx_nxt;

  logic active;
  logic arrived;
  logic take;
  logic is_run;

  always_ff @(posedge clk) begin
    if (bcast.wr_en && (wr_slot == MY_SLOT)) begin
      pid_r   <= bcast.pid;
      arr_r   <= bcast.arrival;
      burst_r <= bcast.burst;
      rem_r   <= bcast.burst;
    end else if (bcast.dec_en && (dec_slot == MY_SLOT)) begin
      rem_r <= rem_r - BURST_W'(1);
    end
  end

  assign active  = (MY_CNT < entry_count);
  assign arrived = ({{(TIME_W - ARR_W){1'b0}}, arr_r} <= bcast.cur_time);
  assign take    = active && arrived && (rem_r != '0) &&
                   (!cand_i.best_found || (rem_r < cand_i.best_rem));
  assign is_run  = bcast.run_valid && (run_slot == MY_SLOT) && active && (rem_r != '0);

  always_comb begin
    cand_nxt = cand_i;
    idx_nxt  = best_idx_i;
    if (take) begin
      cand_nxt.best_found = 1'b1;
      cand_nxt.best_rem   = rem_r;
      cand_nxt.best_pid   = pid_r;
      cand_nxt.best_arr   = arr_r;
      cand_nxt.best_burst = burst_r;
      idx_nxt             = MY_SLOT;
    end
    if (is_run) begin
      cand_nxt.run_found = 1'b1;
      cand_nxt.run_rem   = rem_r;
      cand_nxt.run_pid   = pid_r;
      cand_nxt.run_arr   = arr_r;
      cand_nxt.run_burst = burst_r;
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
    idx_r  <= idx_nxt;
  end

  assign cand_o     = cand_r;
  assign best_idx_o = idx_r;

endmodule

// ----- sv/srtf_process_scheduler.sv -----
// Channel   Direction  Beat contents
// in_       input      mode, proc_id, arrival, burst
// out_      output     rejected, busy_res, running_pid, switched, finished, finish_pid,
//                      completion_time, turnaround, waiting, all_done, tick_time
//
// A load, clear or other beat goes from idle to the finish state, where its result is registered.
// A tick first passes through the scan state, with the candidate walking the chain of slot
// cells, one cell per cycle, before the decision and the update of the chosen slot. No new
// beat is accepted until the result is committed and the block is back in idle.
// Synchronous reset clears counts, time, running process and order state; slot contents
// are not cleared. A result waiting on out_ready holds the next beat in its finish state.
module srtf_process_scheduler
  import srtf_pkg::*;
#(
  parameter int MAX_PROCS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [PID_W-1:0]   in_proc_id,
  input  logic [ARR_W-1:0]   in_arrival,
  input  logic [BURST_W-1:0] in_burst,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_rejected,
  output logic               out_busy_res,
  output logic [PID_W-1:0]   out_running_pid,
  output logic               out_switched,
  output logic               out_finished,
  output logic [PID_W-1:0]   out_finish_pid,
  output logic [TIME_W-1:0]  out_completion_time,
  output logic [TIME_W-1:0]  out_turnaround,
  output logic [TIME_W-1:0]  out_waiting,
  output logic               out_all_done,
  output logic [TIME_W-1:0]  out_tick_time
);

  localparam int SLOT_W = $clog2(MAX_PROCS);
  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_PROCS - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(MAX_PROCS);

  state_t state_r;
  state_t state_nxt;
  logic [SLOT_W-1:0] scan_cnt_r;
  logic [SLOT_W-1:0] scan_cnt_nxt;

  logic [MODE_W-1:0]  mode_r;
  logic [PID_W-1:0]   pid_r;
  logic [ARR_W-1:0]   arr_r;
  logic [BURST_W-1:0] burst_r;

  logic [CNT_W-1:0]  entry_count_r, entry_count_nxt;
  logic [CNT_W-1:0]  completed_count_r, completed_count_nxt;
  logic [TIME_W-1:0] current_time_r, current_time_nxt;
  logic [SLOT_W-1:0] running_slot_r, running_slot_nxt;
  logic              running_valid_r, running_valid_nxt;
  logic [PID_W-1:0]  last_pid_r, last_pid_nxt;
  logic              order_nonempty_r, order_nonempty_nxt;

  logic              out_valid_r;
  logic              rejected_r, rejected_nxt;
  logic              busy_r, busy_nxt;
  logic [PID_W-1:0]  run_pid_r, run_pid_nxt;
  logic              switched_r, switched_nxt;
  logic              finished_r, finished_nxt;
  logic [PID_W-1:0]  fin_pid_r, fin_pid_nxt;
  logic [TIME_W-1:0] ct_r, ct_nxt;
  logic [TIME_W-1:0] tat_r, tat_nxt;
  logic [TIME_W-1:0] wt_r, wt_nxt;
  logic              all_done_r, all_done_nxt;
  logic [TIME_W-1:0] tick_time_r, tick_time_nxt;

  logic              commit;
  logic              in_acc;
  bcast_t            bcast;
  logic [SLOT_W-1:0] dec_slot;

  cand_t             cand_w [MAX_PROCS+1];
  logic [SLOT_W-1:0] idx_w  [MAX_PROCS+1];
  cand_t             res;

  logic               pick_run;
  logic               found;
  logic [PID_W-1:0]   ch_pid;
  logic [ARR_W-1:0]   ch_arr;
  logic [BURST_W-1:0] ch_burst;
  logic [BURST_W-1:0] ch_rem;
  logic [TIME_W-1:0]  ct_calc;
  logic [TIME_W-1:0]  tat_calc;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign commit   = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  assign cand_w[0] = '0;
  assign idx_w[0]  = '0;

  for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
    srtf_cell #(
      .MAX_PROCS(MAX_PROCS),
      .IDX(g)
    ) u_cell (
      .clk(clk),
      .bcast(bcast),
      .wr_slot(entry_count_r[SLOT_W-1:0]),
      .dec_slot(dec_slot),
      .run_slot(running_slot_r),
      .entry_count(entry_count_r),
      .cand_i(cand_w[g]),
      .best_idx_i(idx_w[g]),
      .cand_o(cand_w[g+1]),
      .best_idx_o(idx_w[g+1])
    );
  end

  assign res = cand_w[MAX_PROCS];

  assign pick_run = res.run_found && !(res.best_found && (res.best_rem < res.run_rem));
  assign found    = res.run_found || res.best_found;
  assign ch_pid   = pick_run ? res.run_pid   : res.best_pid;
  assign ch_arr   = pick_run ? res.run_arr   : res.best_arr;
  assign ch_burst = pick_run ? res.run_burst : res.best_burst;
  assign ch_rem   = pick_run ? res.run_rem   : res.best_rem;
  assign dec_slot = pick_run ? running_slot_r : idx_w[MAX_PROCS];
  assign ct_calc  = current_time_r + TIME_W'(1);
  assign tat_calc = ct_calc - {{(TIME_W - ARR_W){1'b0}}, ch_arr};

  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    case (state_r)
      ST_IDLE: begin
        scan_cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = (in_mode == MODE_TICK) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + SLOT_W'(1);
        if (scan_cnt_r == LAST_SLOT) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    bcast.wr_en     = 1'b0;
    bcast.dec_en    = 1'b0;
    bcast.run_valid = running_valid_r;
    bcast.pid       = pid_r;
    bcast.arrival   = arr_r;
    bcast.burst     = burst_r;
    bcast.cur_time  = current_time_r;

    entry_count_nxt     = entry_count_r;
    completed_count_nxt = completed_count_r;
    current_time_nxt    = current_time_r;
    running_slot_nxt    = running_slot_r;
    running_valid_nxt   = running_valid_r;
    last_pid_nxt        = last_pid_r;
    order_nonempty_nxt  = order_nonempty_r;

    rejected_nxt  = 1'b0;
    busy_nxt      = 1'b0;
    run_pid_nxt   = '0;
    switched_nxt  = 1'b0;
    finished_nxt  = 1'b0;
    fin_pid_nxt   = '0;
    ct_nxt        = '0;
    tat_nxt       = '0;
    wt_nxt        = '0;
    tick_time_nxt = current_time_r;

    if (commit) begin
      case (mode_r)
        MODE_LOAD: begin
          if (entry_count_r == FULL_CNT) begin
            rejected_nxt = 1'b1;
          end else begin
            bcast.wr_en     = 1'b1;
            entry_count_nxt = entry_count_r + CNT_W'(1);
            if (burst_r == '0) begin
              completed_count_nxt = completed_count_r + CNT_W'(1);
            end
          end
        end
        MODE_TICK: begin
          current_time_nxt = ct_calc;
          if (found) begin
            bcast.dec_en = 1'b1;
            busy_nxt     = 1'b1;
            run_pid_nxt  = ch_pid;
            if (!order_nonempty_r || (last_pid_r != ch_pid)) begin
              switched_nxt       = 1'b1;
              last_pid_nxt       = ch_pid;
              order_nonempty_nxt = 1'b1;
            end
            if (ch_rem == BURST_W'(1)) begin
              completed_count_nxt = completed_count_r + CNT_W'(1);
              running_valid_nxt   = 1'b0;
              finished_nxt        = 1'b1;
              fin_pid_nxt         = ch_pid;
              ct_nxt              = ct_calc;
              tat_nxt             = tat_calc;
              wt_nxt              = tat_calc - {{(TIME_W - BURST_W){1'b0}}, ch_burst};
            end else begin
              running_valid_nxt = 1'b1;
              running_slot_nxt  = dec_slot;
            end
          end
        end
        MODE_CLEAR: begin
          entry_count_nxt     = '0;
          completed_count_nxt = '0;
          current_time_nxt    = '0;
          running_slot_nxt    = '0;
          running_valid_nxt   = 1'b0;
          last_pid_nxt        = '0;
          order_nonempty_nxt  = 1'b0;
          tick_time_nxt       = '0;
        end
        default: begin
        end
      endcase
    end
    all_done_nxt = (completed_count_nxt == entry_count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      scan_cnt_r        <= '0;
      entry_count_r     <= '0;
      completed_count_r <= '0;
      current_time_r    <= '0;
      running_slot_r    <= '0;
      running_valid_r   <= 1'b0;
      last_pid_r        <= '0;
      order_nonempty_r  <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      state_r           <= state_nxt;
      scan_cnt_r        <= scan_cnt_nxt;
      entry_count_r     <= entry_count_nxt;
      completed_count_r <= completed_count_nxt;
      current_time_r    <= current_time_nxt;
      running_slot_r    <= running_slot_nxt;
      running_valid_r   <= running_valid_nxt;
      last_pid_r        <= last_pid_nxt;
      order_nonempty_r  <= order_nonempty_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r  <= in_mode;
      pid_r   <= in_proc_id;
      arr_r   <= in_arrival;
      burst_r <= in_burst;
    end
    if (commit) begin
      rejected_r  <= rejected_nxt;
      busy_r      <= busy_nxt;
      run_pid_r   <= run_pid_nxt;
      switched_r  <= switched_nxt;
      finished_r  <= finished_nxt;
      fin_pid_r   <= fin_pid_nxt;
      ct_r        <= ct_nxt;
      tat_r       <= tat_nxt;
      wt_r        <= wt_nxt;
      all_done_r  <= all_done_nxt;
      tick_time_r <= tick_time_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_rejected        = rejected_r;
  assign out_busy_res        = busy_r;
  assign out_running_pid     = run_pid_r;
  assign out_switched        = switched_r;
  assign out_finished        = finished_r;
  assign out_finish_pid      = fin_pid_r;
  assign out_completion_time = ct_r;
  assign out_turnaround      = tat_r;
  assign out_waiting         = wt_r;
  assign out_all_done        = all_done_r;
  assign out_tick_time       = tick_time_r;

`ifndef ASSERT_OFF
  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    completed_count_r <= entry_count_r)
    else $error("completed count exceeds entry count");

  a_run_slot: assert property (@(posedge clk) disable iff (!rst_n)
    running_valid_r |-> (CNT_W'(running_slot_r) < entry_count_r))
    else $error("running slot outside loaded table");

  a_finish_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && finished_nxt) |=> !running_valid_r)
    else $error("finished process still marked running");

  a_scan_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> ($stable(current_time_r) && $stable(entry_count_r)))
    else $error("scheduler state changed during a scan");
`endif

endmodule

// ----- bench/testbench.sv -----
module testbench;
  import srtf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
  localparam int LIMIT_CYCLES = 800000;
  localparam int DRAIN_CYCLES = 3 * (SLOTS + 2);
  localparam int TARGET_ITEMS = 700;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [PID_W-1:0]   pid;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
  } sched_item_t;

  typedef struct packed {
    logic              rejected;
    logic              busy;
    logic [PID_W-1:0]  running_pid;
    logic              switched;
    logic              finished;
    logic [PID_W-1:0]  finish_pid;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;
    logic [TIME_W-1:0] tick_time;
  } sched_result_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  wire logic          in_ready;
  logic [MODE_W-1:0]  in_mode = MODE_NOP;
  logic [PID_W-1:0]   in_proc_id = '0;
  logic [ARR_W-1:0]   in_arrival = '0;
  logic [BURST_W-1:0] in_burst = '0;
  wire logic          out_valid;
  logic               out_ready = 1'b0;
  wire logic          out_rejected;
  wire logic          out_busy_res;
  wire logic [PID_W-1:0]  out_running_pid;
  wire logic          out_switched;
  wire logic          out_finished;
  wire logic [PID_W-1:0]  out_finish_pid;
  wire logic [TIME_W-1:0] out_completion_time;
  wire logic [TIME_W-1:0] out_turnaround;
  wire logic [TIME_W-1:0] out_waiting;
  wire logic          out_all_done;
  wire logic [TIME_W-1:0] out_tick_time;

  srtf_process_scheduler #(.MAX_PROCS(SLOTS)) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_proc_id          (in_proc_id),
    .in_arrival          (in_arrival),
    .in_burst            (in_burst),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_rejected        (out_rejected),
    .out_busy_res        (out_busy_res),
    .out_running_pid     (out_running_pid),
    .out_switched        (out_switched),
    .out_finished        (out_finished),
    .out_finish_pid      (out_finish_pid),
    .out_completion_time (out_completion_time),
    .out_turnaround      (out_turnaround),
    .out_waiting         (out_waiting),
    .out_all_done        (out_all_done),
    .out_tick_time       (out_tick_time)
  );

  sched_item_t   pending_beats[$];
  sched_result_t expected_results[$];

  logic [PID_W-1:0]   slot_pid[SLOTS];
  logic [ARR_W-1:0]   slot_arrival[SLOTS];
  logic [BURST_W-1:0] slot_burst[SLOTS];
  logic [BURST_W-1:0] slot_remaining[SLOTS];
  int unsigned        loaded_count;
  int unsigned        done_count;
  logic [TIME_W-1:0]  sched_now;
  int unsigned        run_slot;
  bit                 run_active;
  logic [PID_W-1:0]   last_run_pid;
  bit                 order_started;

  logic [31:0] cycles = '0;
  wire logic   calm = (cycles[10:9] == 2'd0);
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned errors = 0;
  int unsigned result_count = 0;
  int unsigned n_loads = 0, n_rejects = 0, n_ticks = 0, n_busy = 0;
  int unsigned n_done = 0, n_clears = 0, n_other = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic void wipe_schedule();
    for (int i = 0; i < SLOTS; i++) begin
      slot_pid[i] = '0;
      slot_arrival[i] = '0;
      slot_burst[i] = '0;
      slot_remaining[i] = '0;
    end
    loaded_count = 0;
    done_count = 0;
    sched_now = '0;
    run_slot = 0;
    run_active = 1'b0;
    last_run_pid = '0;
    order_started = 1'b0;
  endfunction

  initial wipe_schedule();

  function automatic sched_result_t schedule_beat(sched_item_t it);
    sched_result_t     r;
    int unsigned       pick;
    logic [BURST_W:0]  pick_rem;
    bit                found;
    logic [PID_W-1:0]  p;
    logic [TIME_W-1:0] ct;
    logic [TIME_W-1:0] tat;
    r = '0;
    pick = 0;
    pick_rem = 17'h10000;
    found = 1'b0;
    r.tick_time = sched_now;
    if (it.mode == MODE_LOAD) begin
      if (loaded_count >= SLOTS) begin
        r.rejected = 1'b1;
      end else begin
        slot_pid[loaded_count] = it.pid;
        slot_arrival[loaded_count] = it.arrival;
        slot_burst[loaded_count] = it.burst;
        slot_remaining[loaded_count] = it.burst;
        if (it.burst == '0) done_count++;
        loaded_count++;
      end
    end else if (it.mode == MODE_TICK) begin
      if (run_active && run_slot < loaded_count && slot_remaining[run_slot] != '0) begin
        pick = run_slot;
        pick_rem = {1'b0, slot_remaining[run_slot]};
        found = 1'b1;
      end
      for (int j = 0; j < loaded_count; j++) begin
        if (TIME_W'(slot_arrival[j]) <= sched_now && slot_remaining[j] != '0 &&
            {1'b0, slot_remaining[j]} < pick_rem) begin
          pick = j;
          pick_rem = {1'b0, slot_remaining[j]};
          found = 1'b1;
        end
      end
      if (found) begin
        p = slot_pid[pick];
        r.busy = 1'b1;
        r.running_pid = p;
        if (!order_started || last_run_pid != p) begin
          r.switched = 1'b1;
          last_run_pid = p;
          order_started = 1'b1;
        end
        slot_remaining[pick] = slot_remaining[pick] - 1'b1;
        if (slot_remaining[pick] == '0) begin
          ct = sched_now + 1'b1;
          tat = ct - TIME_W'(slot_arrival[pick]);
          done_count++;
          run_active = 1'b0;
          r.finished = 1'b1;
          r.finish_pid = p;
          r.completion_time = ct;
          r.turnaround = tat;
          r.waiting = tat - TIME_W'(slot_burst[pick]);
        end else begin
          run_active = 1'b1;
          run_slot = pick;
        end
      end
      sched_now = sched_now + 1'b1;
    end else if (it.mode == MODE_CLEAR) begin
      wipe_schedule();
      r.tick_time = sched_now;
    end
    r.all_done = (done_count == loaded_count);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("result %0d: %s is %0h, expected %0h", result_count, what, got, want);
  endtask

  task automatic add_load(int unsigned pid, int unsigned arr, int unsigned bst);
    sched_item_t it;
    it.mode = MODE_LOAD;
    it.pid = PID_W'(pid);
    it.arrival = ARR_W'(arr);
    it.burst = BURST_W'(bst);
    pending_beats.insert(pending_beats.size(), it);
  endtask

  task automatic add_op(logic [MODE_W-1:0] mode);
    sched_item_t it;
    it.mode = mode;
    it.pid = PID_W'($urandom);
    it.arrival = ARR_W'($urandom);
    it.burst = BURST_W'($urandom);
    pending_beats.insert(pending_beats.size(), it);
  endtask

  always @(posedge clk) begin : drive_beats
    sched_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        nxt = pending_beats.pop_front();
        in_mode <= nxt.mode;
        in_proc_id <= nxt.pid;
        in_arrival <= nxt.arrival;
        in_burst <= nxt.burst;
        in_valid <= 1'b1;
        gap_left = calm ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch_results
    sched_result_t want;
    sched_item_t   seen;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat, tick_time", out_tick_time, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_rejected !== want.rejected)
            report_mismatch("rejected", out_rejected, want.rejected);
          if (out_busy_res !== want.busy)
            report_mismatch("busy_res", out_busy_res, want.busy);
          if (out_running_pid !== want.running_pid)
            report_mismatch("running_pid", out_running_pid, want.running_pid);
          if (out_switched !== want.switched)
            report_mismatch("switched", out_switched, want.switched);
          if (out_finished !== want.finished)
            report_mismatch("finished", out_finished, want.finished);
          if (out_finish_pid !== want.finish_pid)
            report_mismatch("finish_pid", out_finish_pid, want.finish_pid);
          if (out_completion_time !== want.completion_time)
            report_mismatch("completion_time", out_completion_time, want.completion_time);
          if (out_turnaround !== want.turnaround)
            report_mismatch("turnaround", out_turnaround, want.turnaround);
          if (out_waiting !== want.waiting)
            report_mismatch("waiting", out_waiting, want.waiting);
          if (out_all_done !== want.all_done)
            report_mismatch("all_done", out_all_done, want.all_done);
          if (out_tick_time !== want.tick_time)
            report_mismatch("tick_time", out_tick_time, want.tick_time);
        end
      end
      if (in_valid && in_ready) begin
        seen.mode = in_mode;
        seen.pid = in_proc_id;
        seen.arrival = in_arrival;
        seen.burst = in_burst;
        want = schedule_beat(seen);
        expected_results.insert(expected_results.size(), want);
        case (in_mode)
          MODE_LOAD: begin
            n_loads++;
            if (want.rejected) n_rejects++;
          end
          MODE_TICK: begin
            n_ticks++;
            if (want.busy) n_busy++;
            if (want.finished) n_done++;
          end
          MODE_CLEAR: n_clears++;
          default: n_other++;
        endcase
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned kind, n, arr, a, b, work, ticks;

    // Directed: idle tick, no-op mode, clear, then a short schedule with a zero
    // burst, an out-of-order arrival, a preemption and field extremes.
    add_op(MODE_TICK);
    add_op(MODE_NOP);
    add_op(MODE_CLEAR);
    add_load(8'h00, 0, 1);
    add_load(8'hFF, 0, 0);
    add_load(8'hAA, 2, 3);
    add_load(8'h55, 1, 2);
    add_op(MODE_TICK);
    add_op(MODE_TICK);
    add_op(MODE_TICK);
    add_op(MODE_TICK);
    add_load(8'h07, 4, 1);
    add_load(8'h08, 4, 1);
    add_op(MODE_TICK);
    add_op(MODE_TICK);
    add_op(MODE_TICK);
    add_op(MODE_TICK);
    add_op(MODE_TICK);
    add_op(MODE_TICK);
    add_load(8'h80, 16'hFFFF, 16'hFFFF);
    add_load(8'h01, 16'h0000, 16'hFFFF);
    add_op(MODE_TICK);
    add_op(MODE_NOP);
    add_op(MODE_CLEAR);

    while (pending_beats.size() < TARGET_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        add_op(MODE_CLEAR);
        n = $urandom_range(1, SLOTS);
        if ($urandom_range(0, 7) == 0) n = SLOTS + $urandom_range(1, 3);
        arr = 0;
        work = 0;
        for (int k = 0; k < n; k++) begin
          arr += $urandom_range(0, 3);
          b = $urandom_range(1, 6);
          if ($urandom_range(0, 15) == 0) b = 0;
          a = arr;
          if ($urandom_range(0, 9) == 0) a = $urandom_range(0, arr);
          add_load($urandom_range(0, 255), a, b);
          if (k < SLOTS) work += b;
        end
        ticks = arr + work + $urandom_range(0, 3);
        for (int k = 0; k < ticks; k++) begin
          if ($urandom_range(0, 24) == 0) add_load($urandom_range(0, 255), arr + k,
                                                   $urandom_range(1, 4));
          add_op(MODE_TICK);
        end
      end else if (kind == 7) begin
        repeat ($urandom_range(4, 12)) begin
          add_op(MODE_W'($urandom_range(0, 3)));
          if (pending_beats[$].mode == MODE_LOAD && pending_beats[$].burst == '0)
            pending_beats[$].burst = BURST_W'($urandom_range(1, 3));
        end
      end else if (kind == 8) begin
        repeat ($urandom_range(2, 5)) add_load($urandom, $urandom, $urandom);
        repeat ($urandom_range(1, 6)) add_op(MODE_TICK);
      end else begin
        repeat ($urandom_range(1, 4)) add_load($urandom_range(0, 255), $urandom_range(0, 40),
                                               $urandom_range(1, 5));
        repeat ($urandom_range(2, 12)) add_op(MODE_TICK);
      end
    end

    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d loads (%0d rejected), %0d ticks (%0d busy, %0d completions)",
             n_loads, n_rejects, n_ticks, n_busy, n_done);
    $display("plus %0d clears and %0d no-op beats, %0d results checked, %0d mismatches",
             n_clears, n_other, result_count, errors);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ----- srtf_process_scheduler.f -----
sv/srtf_pkg.sv
sv/srtf_cell.sv
sv/srtf_process_scheduler.sv
bench/testbench.sv
